### design/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants for the BMP stream to framebuffer unit.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned INDEX_W    = 19;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned X_ORIGIN_W = 10;
  localparam int unsigned Y_ORIGIN_W = 9;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_X_ORIGIN = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_ORIGIN = 4'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] file_byte;
    logic              start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [X_ORIGIN_W-1:0] x;
    logic [Y_ORIGIN_W-1:0] y;
  } origin_t;

endpackage

### design/bsf_stream_if.sv
// ----------------------------------------------------------------------------
// bsf_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface bsf_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### design/bsf_cfg_regs.sv
// ----------------------------------------------------------------------------
// bsf_cfg_regs
// Origin registers written through the configuration channel.
// ----------------------------------------------------------------------------
module bsf_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  bsf_stream_if.sink        cfg_write,
  output bsf_pkg::origin_t  origin
);

  logic [bsf_pkg::X_ORIGIN_W-1:0] x_origin_r;
  logic [bsf_pkg::Y_ORIGIN_W-1:0] y_origin_r;

  assign cfg_write.ready = 1'b1;
  assign origin.x = x_origin_r;
  assign origin.y = y_origin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= '0;
      y_origin_r <= '0;
    end else if (cfg_write.valid) begin
      if (cfg_write.data.index == bsf_pkg::CFG_X_ORIGIN) begin
        x_origin_r <= cfg_write.data.data[bsf_pkg::X_ORIGIN_W-1:0];
      end else if (cfg_write.data.index == bsf_pkg::CFG_Y_ORIGIN) begin
        y_origin_r <= cfg_write.data.data[bsf_pkg::Y_ORIGIN_W-1:0];
      end
    end
  end

endmodule

### design/bsf_parser.sv
// ----------------------------------------------------------------------------
// bsf_parser
// Input register, header capture and pixel assembly; emits on-screen pixels
// as screen coordinates into a pixel register.
// ----------------------------------------------------------------------------
module bsf_parser #(
  parameter int unsigned SCREEN_W = 800,
  parameter int unsigned SCREEN_H = 480,
  parameter int unsigned MAX_DIM  = 2048,
  localparam int unsigned XW = $clog2(SCREEN_W),
  localparam int unsigned YW = $clog2(SCREEN_H)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bsf_stream_if.sink                   in_stream,
  input  bsf_pkg::origin_t             origin,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output logic [XW-1:0]                pix_x,
  output logic [YW-1:0]                pix_y,
  output logic [bsf_pkg::COLOR_W-1:0]  pix_color,
  output logic                         pix_last
);

  localparam int unsigned WW   = $clog2(MAX_DIM + 1);
  localparam int unsigned SWW  = $clog2(SCREEN_W + 1);
  localparam int unsigned SHW  = $clog2(SCREEN_H + 1);
  localparam int unsigned XA   = (WW > bsf_pkg::X_ORIGIN_W) ? WW : bsf_pkg::X_ORIGIN_W;
  localparam int unsigned XSW  = ((XA > SWW) ? XA : SWW) + 1;
  localparam int unsigned YA   = (WW > bsf_pkg::Y_ORIGIN_W) ? WW : bsf_pkg::Y_ORIGIN_W;
  localparam int unsigned YSW  = ((YA > SHW) ? YA : SHW) + 1;

  localparam logic [5:0] OFF_WIDTH_END  = 6'h15;
  localparam logic [5:0] OFF_HEIGHT_END = 6'h19;
  localparam logic [5:0] OFF_DEPTH_END  = 6'h1D;
  localparam logic [5:0] OFF_HEADER_END = 6'h35;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_PAD,
    PH_DONE
  } phase_t;

  // input register
  logic                        in_vld_r;
  logic [bsf_pkg::BYTE_W-1:0]  in_byte_r;
  logic                        in_sof_r;

  // parse state
  phase_t         phase_r,  phase_nxt,  cur_phase;
  logic [5:0]     off_r,    off_nxt,    cur_off;
  logic [31:0]    hs_r,     hs_nxt,     cur_hs;
  logic [WW-1:0]  width_r,  width_nxt,  cur_width;
  logic           wbad_r,   wbad_nxt,   cur_wbad;
  logic [WW-1:0]  hmag_r,   hmag_nxt,   cur_hmag;
  logic           hbad_r,   hbad_nxt,   cur_hbad;
  logic           hneg_r,   hneg_nxt,   cur_hneg;
  logic [2:0]     bpp_r,    bpp_nxt,    cur_bpp;
  logic [WW-1:0]  col_r,    col_nxt,    cur_col;
  logic [WW-1:0]  row_r,    row_nxt,    cur_row;
  logic [1:0]     bip_r,    bip_nxt,    cur_bip;
  logic [23:0]    acc_r,    acc_nxt,    cur_acc;
  logic [1:0]     pad_r,    pad_nxt,    cur_pad;

  // pixel register
  logic                        pix_vld_r;
  logic [XW-1:0]               pix_x_r;
  logic [YW-1:0]               pix_y_r;
  logic [bsf_pkg::COLOR_W-1:0] pix_color_r;
  logic                        pix_last_r;

  logic                        adv;
  logic                        emit;
  logic [31:0]                 hs_shift;
  logic [31:0]                 hmag32;
  logic [15:0]                 depth;
  logic                        header_ok;
  logic [23:0]                 acc_add;
  logic                        px_done;
  logic [7:0]                  alpha;
  logic [bsf_pkg::COLOR_W-1:0] color;
  logic [XSW-1:0]              x_pos;
  logic [YSW-1:0]              y_pos;
  logic [WW-1:0]               col_inc;
  logic [WW-1:0]               row_inc;
  logic                        onscreen;
  logic                        last;
  logic [1:0]                  row_mod;
  logic [1:0]                  pad_calc;

  assign adv             = in_vld_r && (!pix_vld_r || pix_ready);
  assign in_stream.ready = !in_vld_r || adv;

  assign pix_valid = pix_vld_r;
  assign pix_x     = pix_x_r;
  assign pix_y     = pix_y_r;
  assign pix_color = pix_color_r;
  assign pix_last  = pix_last_r;

  always_comb begin
    cur_phase = phase_r;
    cur_off   = off_r;
    cur_hs    = hs_r;
    cur_width = width_r;
    cur_wbad  = wbad_r;
    cur_hmag  = hmag_r;
    cur_hbad  = hbad_r;
    cur_hneg  = hneg_r;
    cur_bpp   = bpp_r;
    cur_col   = col_r;
    cur_row   = row_r;
    cur_bip   = bip_r;
    cur_acc   = acc_r;
    cur_pad   = pad_r;
    if (in_sof_r) begin
      cur_phase = PH_HEADER;
      cur_off   = '0;
      cur_hs    = '0;
      cur_width = '0;
      cur_wbad  = 1'b1;
      cur_hmag  = '0;
      cur_hbad  = 1'b1;
      cur_hneg  = 1'b0;
      cur_bpp   = '0;
      cur_col   = '0;
      cur_row   = '0;
      cur_bip   = '0;
      cur_acc   = '0;
      cur_pad   = '0;
    end

    hs_shift  = {in_byte_r, cur_hs[31:8]};
    hmag32    = hs_shift[31] ? (32'd0 - hs_shift) : hs_shift;
    depth     = hs_shift[31:16];
    header_ok = (cur_bpp != 3'd0) && !cur_wbad && !cur_hbad;

    unique case (cur_bip)
      2'd0:    acc_add = {16'h0, in_byte_r};
      2'd1:    acc_add = {8'h0, in_byte_r, 8'h0};
      2'd2:    acc_add = {in_byte_r, 16'h0};
      default: acc_add = 24'h0;
    endcase

    px_done  = ({1'b0, cur_bip} + 3'd1) >= cur_bpp;
    alpha    = (cur_bpp == 3'd4) ? in_byte_r : 8'h0;
    color    = {alpha, cur_acc | acc_add};
    x_pos    = XSW'(origin.x) + XSW'(cur_col);
    y_pos    = cur_hneg ? (YSW'(origin.y) + YSW'(cur_row))
                        : (YSW'(origin.y) + YSW'(cur_hmag - WW'(1) - cur_row));
    onscreen = (x_pos < XSW'(SCREEN_W)) && (y_pos < YSW'(SCREEN_H));
    col_inc  = cur_col + WW'(1);
    row_inc  = cur_row + WW'(1);
    last     = (col_inc == cur_width) && (row_inc == cur_hmag);
    row_mod  = 2'(cur_width[1:0] * cur_bpp[1:0]);
    pad_calc = 2'(2'd0 - row_mod);

    phase_nxt = cur_phase;
    off_nxt   = cur_off;
    hs_nxt    = cur_hs;
    width_nxt = cur_width;
    wbad_nxt  = cur_wbad;
    hmag_nxt  = cur_hmag;
    hbad_nxt  = cur_hbad;
    hneg_nxt  = cur_hneg;
    bpp_nxt   = cur_bpp;
    col_nxt   = cur_col;
    row_nxt   = cur_row;
    bip_nxt   = cur_bip;
    acc_nxt   = cur_acc;
    pad_nxt   = cur_pad;
    emit      = 1'b0;

    unique case (cur_phase)
      PH_HEADER: begin
        hs_nxt = hs_shift;
        if (cur_off == OFF_WIDTH_END) begin
          width_nxt = hs_shift[WW-1:0];
          wbad_nxt  = (hs_shift == 32'd0) || (hs_shift > 32'(MAX_DIM));
        end else if (cur_off == OFF_HEIGHT_END) begin
          hmag_nxt = hmag32[WW-1:0];
          hneg_nxt = hs_shift[31];
          hbad_nxt = (hmag32 == 32'd0) || (hmag32 > 32'(MAX_DIM));
        end else if (cur_off == OFF_DEPTH_END) begin
          bpp_nxt = (depth == 16'd24) ? 3'd3 : ((depth == 16'd32) ? 3'd4 : 3'd0);
        end
        if (cur_off >= OFF_HEADER_END) begin
          phase_nxt = header_ok ? PH_PIXELS : PH_DONE;
          col_nxt   = '0;
          row_nxt   = '0;
          bip_nxt   = '0;
          acc_nxt   = '0;
          pad_nxt   = '0;
        end else begin
          off_nxt = cur_off + 6'd1;
        end
      end
      PH_PIXELS: begin
        acc_nxt = cur_acc | acc_add;
        if (px_done) begin
          emit    = onscreen;
          bip_nxt = '0;
          acc_nxt = '0;
          col_nxt = col_inc;
          if (col_inc >= cur_width) begin
            col_nxt = '0;
            row_nxt = row_inc;
            if (row_inc >= cur_hmag) begin
              phase_nxt = PH_DONE;
            end else begin
              pad_nxt = pad_calc;
              if (pad_calc != 2'd0) begin
                phase_nxt = PH_PAD;
              end
            end
          end
        end else begin
          bip_nxt = cur_bip + 2'd1;
        end
      end
      PH_PAD: begin
        if (cur_pad != 2'd0) begin
          pad_nxt = cur_pad - 2'd1;
        end
        if (cur_pad <= 2'd1) begin
          phase_nxt = PH_PIXELS;
        end
      end
      PH_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      pix_vld_r <= 1'b0;
      phase_r   <= PH_HEADER;
      off_r     <= '0;
      hs_r      <= '0;
      width_r   <= '0;
      wbad_r    <= 1'b1;
      hmag_r    <= '0;
      hbad_r    <= 1'b1;
      hneg_r    <= 1'b0;
      bpp_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      bip_r     <= '0;
      acc_r     <= '0;
      pad_r     <= '0;
    end else begin
      if (in_stream.valid && in_stream.ready) begin
        in_vld_r  <= 1'b1;
        in_byte_r <= in_stream.data.file_byte;
        in_sof_r  <= in_stream.data.start_of_file;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end

      if (adv) begin
        phase_r     <= phase_nxt;
        off_r       <= off_nxt;
        hs_r        <= hs_nxt;
        width_r     <= width_nxt;
        wbad_r      <= wbad_nxt;
        hmag_r      <= hmag_nxt;
        hbad_r      <= hbad_nxt;
        hneg_r      <= hneg_nxt;
        bpp_r       <= bpp_nxt;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
        bip_r       <= bip_nxt;
        acc_r       <= acc_nxt;
        pad_r       <= pad_nxt;
        pix_vld_r   <= emit;
        pix_x_r     <= x_pos[XW-1:0];
        pix_y_r     <= y_pos[YW-1:0];
        pix_color_r <= color;
        pix_last_r  <= last;
      end else if (pix_ready) begin
        pix_vld_r <= 1'b0;
      end
    end
  end

endmodule

### design/bsf_pixel_out.sv
// ----------------------------------------------------------------------------
// bsf_pixel_out
// Converts screen coordinates to a framebuffer word index; result register.
// ----------------------------------------------------------------------------
module bsf_pixel_out #(
  parameter int unsigned SCREEN_W = 800,
  parameter int unsigned SCREEN_H = 480,
  localparam int unsigned XW = $clog2(SCREEN_W),
  localparam int unsigned YW = $clog2(SCREEN_H)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  logic [XW-1:0]                pix_x,
  input  logic [YW-1:0]                pix_y,
  input  logic [bsf_pkg::COLOR_W-1:0]  pix_color,
  input  logic                         pix_last,
  bsf_stream_if.source                 out_stream
);

  localparam int unsigned FW = XW + YW + 1;
  localparam int unsigned PW = (FW > bsf_pkg::INDEX_W) ? FW : bsf_pkg::INDEX_W;

  logic                         out_vld_r;
  logic [bsf_pkg::INDEX_W-1:0]  index_r;
  logic [bsf_pkg::COLOR_W-1:0]  color_r;
  logic                         last_r;
  logic [PW-1:0]                linear;

  assign pix_ready = !out_vld_r || out_stream.ready;
  assign linear    = PW'(pix_y) * PW'(SCREEN_W) + PW'(pix_x);

  assign out_stream.valid            = out_vld_r;
  assign out_stream.data.pixel_index = index_r;
  assign out_stream.data.pixel_color = color_r;
  assign out_stream.data.last_pixel  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pix_ready) begin
      out_vld_r <= pix_valid;
      if (pix_valid) begin
        index_r <= linear[bsf_pkg::INDEX_W-1:0];
        color_r <= pix_color;
        last_r  <= pix_last;
      end
    end
  end

endmodule

### design/bmp_stream_to_framebuffer_unit.sv
// Path: an accepted byte enters the input register, the parse step moves it into the
// pixel register, then the pixel becomes a result in the index register.
// Throughput: one byte per clock; the parse step updates all header and pixel state
// for each accepted byte, and a stalled output holds the pipeline through valid/ready.
// Reset (synchronous, rst_n low): origins are zero and the parser waits at offset 0.
// ----------------------------------------------------------------------------
// bmp_stream_to_framebuffer_unit
// Decodes a 24/32-bit BMP byte stream into framebuffer pixel writes.
// ----------------------------------------------------------------------------
module bmp_stream_to_framebuffer_unit #(
  parameter int unsigned SCREEN_W = 800,
  parameter int unsigned SCREEN_H = 480,
  parameter int unsigned MAX_DIM  = 2048
) (
  input  logic          clk,
  input  logic          rst_n,
  bsf_stream_if.sink    in_stream,
  bsf_stream_if.source  out_stream,
  bsf_stream_if.sink    cfg_write
);

  localparam int unsigned XW = $clog2(SCREEN_W);
  localparam int unsigned YW = $clog2(SCREEN_H);

  bsf_pkg::origin_t             origin;
  logic                         pix_valid;
  logic                         pix_ready;
  logic [XW-1:0]                pix_x;
  logic [YW-1:0]                pix_y;
  logic [bsf_pkg::COLOR_W-1:0]  pix_color;
  logic                         pix_last;

  bsf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .origin    (origin)
  );

  bsf_parser #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .MAX_DIM  (MAX_DIM)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .origin    (origin),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_color (pix_color),
    .pix_last  (pix_last)
  );

  bsf_pixel_out #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_color  (pix_color),
    .pix_last   (pix_last),
    .out_stream (out_stream)
  );

endmodule
